/* design/graham_scan_convex_hull_core_defines.svh */
// assertion macros shared by the rtl
`ifndef GRAHAM_SCAN_CONVEX_HULL_CORE_DEFINES_SVH
`define GRAHAM_SCAN_CONVEX_HULL_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_NEVER(lbl, c, r, a) \
    lbl: assert property (@(posedge c) disable iff (!r) !(a)) \
        else $error("assertion failed");

`define ASSERT_IMPL(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
        else $error("assertion failed");

`define ASSERT_LAT(lbl, c, r, a, n, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> ##n (b)) \
        else $error("assertion failed");

`else

`define ASSERT_NEVER(lbl, c, r, a)
`define ASSERT_IMPL(lbl, c, r, a, b)
`define ASSERT_LAT(lbl, c, r, a, n, b)

`endif

`endif

/* design/gsch_pkg.sv */
`timescale 1ns / 1ps

package gsch_pkg;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic start;
        logic sub;
    } mac_ctl_t;

    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_M1,
        MAC_M2,
        MAC_SUM
    } mac_state_t;

    typedef enum logic [5:0] {
        S_LOAD,
        S_START,
        S_ANC_RD,
        S_ANC_CMP,
        S_CLS_INIT,
        S_CLS_RD,
        S_CLS_P,
        S_CLS_J,
        S_CLS_JQ,
        S_CLS_Q,
        S_CLS_T,
        S_CLS_D1,
        S_CLS_D2,
        S_CLS_NEW,
        S_CLS_NEXT,
        S_CHK,
        S_SRT_RD,
        S_SRT_K,
        S_SRT_KP,
        S_SRT_J,
        S_SRT_JQ,
        S_SRT_Q,
        S_SRT_T,
        S_SRT_PUT,
        S_SCN_INIT,
        S_SCN_I1,
        S_SCN_I2,
        S_SCN_RD,
        S_SCN_P,
        S_SCN_PP,
        S_SCN_TOP,
        S_SCN_O,
        S_SCN_M,
        S_SCN_MQ,
        S_SCN_T,
        S_SCN_PUSH,
        S_OUT_INIT,
        S_OUT_RD,
        S_OUT_S,
        S_OUT_SET,
        S_OUT_WAIT
    } top_state_t;

endpackage

/* design/gsch_mac.sv */
`timescale 1ns / 1ps

// fa*fb -/+ fc*fd with one shared multiplier, registered in M1, M2 and SUM
module gsch_mac #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gsch_pkg::mac_ctl_t            ctl,
    input  logic signed [COORD_BITS:0]    fa,
    input  logic signed [COORD_BITS:0]    fb,
    input  logic signed [COORD_BITS:0]    fc,
    input  logic signed [COORD_BITS:0]    fd,
    output logic                          done,
    output logic signed [2*COORD_BITS+3:0] res
);
    import gsch_pkg::*;

    localparam int PW = 2 * COORD_BITS + 2;
    localparam int RW = 2 * COORD_BITS + 4;

    mac_state_t state_reg, state_next;
    logic signed [COORD_BITS:0] fa_reg, fb_reg, fc_reg, fd_reg;
    logic sub_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [RW-1:0] res_reg;
    logic done_reg;
    logic signed [COORD_BITS:0] mul_l, mul_r;
    logic signed [PW-1:0] prod;
    logic p1_en, p2_en, sum_en;

    always_comb
    begin
        unique case (state_reg)
            MAC_IDLE: state_next = ctl.start ? MAC_M1 : MAC_IDLE;
            MAC_M1:   state_next = MAC_M2;
            MAC_M2:   state_next = MAC_SUM;
            MAC_SUM:  state_next = MAC_IDLE;
            default:  state_next = MAC_IDLE;
        endcase
    end

    always_comb
    begin
        p1_en  = (state_reg == MAC_M1);
        p2_en  = (state_reg == MAC_M2);
        sum_en = (state_reg == MAC_SUM);
        mul_l  = p2_en ? fc_reg : fa_reg;
        mul_r  = p2_en ? fd_reg : fb_reg;
    end

    assign prod = mul_l * mul_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MAC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= sum_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MAC_IDLE && ctl.start)
        begin
            fa_reg  <= fa;
            fb_reg  <= fb;
            fc_reg  <= fc;
            fd_reg  <= fd;
            sub_reg <= ctl.sub;
        end
        if (p1_en)
        begin
            p1_reg <= prod;
        end
        if (p2_en)
        begin
            p2_reg <= prod;
        end
        if (sum_en)
        begin
            if (sub_reg)
            begin
                res_reg <= RW'(p1_reg) - RW'(p2_reg);
            end
            else
            begin
                res_reg <= RW'(p1_reg) + RW'(p2_reg);
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* design/graham_scan_convex_hull_core.sv */
`timescale 1ns / 1ps
// points load one per cycle while s_tready is high; the last point starts the hull run
// anchor search reads each point once; class build runs a turn test of each point against
// each class, plus two distance tests on a tie; sort inserts each class by turn tests; scan
// pops by turn tests; one shared multiplier serves every turn and distance test
// each vertex is read then held for m_tready; s_tready is low until the final result is taken
// rst_n is asynchronous: control returns to loading an empty set, stores stay undefined
module graham_scan_convex_hull_core #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_x, point_y, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // last_point
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hull_x, hull_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // last_vertex
    output logic                  m_tlast,
    // status
    output logic [1:0]            m_tuser
);
    import gsch_pkg::*;

    `include "graham_scan_convex_hull_core_defines.svh"

    localparam int CB = COORD_BITS;
    localparam int DW = ((2 * CB + 7) / 8) * 8;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int RW = 2 * CB + 4;
    localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

    function automatic logic signed [CB:0] dif(input logic signed [CB-1:0] u,
                                               input logic signed [CB-1:0] v);
        dif = $signed({u[CB-1], u}) - $signed({v[CB-1], v});
    endfunction

    top_state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, n_reg, i_reg, j_reg, nc_reg, d_reg;
    logic ovf_reg;
    logic [AW-1:0] aslot_reg, key_reg, qslot_reg;
    logic signed [CB-1:0] ax_reg, ay_reg, px_reg, py_reg, qx_reg, qy_reg, ox_reg, oy_reg;
    logic signed [RW-1:0] dist_reg;
    logic signed [CB-1:0] out_x_reg, out_y_reg;
    logic out_last_reg;
    logic [1:0] out_st_reg;

    logic signed [CB-1:0] store_x_mem [MAX_POINTS];
    logic signed [CB-1:0] store_y_mem [MAX_POINTS];
    logic [AW-1:0] cls_mem [MAX_POINTS];
    logic [AW-1:0] hull_mem [MAX_POINTS];
    logic signed [CB-1:0] st_rd_x, st_rd_y;
    logic [AW-1:0] cls_rd, hull_rd;

    logic st_we;
    logic [AW-1:0] st_raddr, cls_raddr, cls_waddr, cls_wdata;
    logic [AW-1:0] hull_raddr, hull_waddr, hull_wdata;
    logic cls_we, hull_we;

    mac_ctl_t mac_ctl;
    logic signed [CB:0] fa, fb, fc, fd;
    logic mac_done;
    logic signed [RW-1:0] mac_res;
    logic res_zero, res_neg;

    logic s_acc;
    logic signed [CB-1:0] in_x, in_y;
    logic [CW-1:0] i_inc, j_inc, j_dec, d_dec, d_dec2;

    assign s_acc    = s_tvalid && s_tready;
    assign in_x     = $signed(s_tdata[CB-1:0]);
    assign in_y     = $signed(s_tdata[2*CB-1:CB]);
    assign i_inc    = i_reg + 1'b1;
    assign j_inc    = j_reg + 1'b1;
    assign j_dec    = j_reg - 1'b1;
    assign d_dec    = d_reg - 1'b1;
    assign d_dec2   = d_reg - 2'd2;
    assign res_zero = (mac_res == '0);
    assign res_neg  = mac_res[RW-1];

    gsch_mac #(
        .COORD_BITS(CB)
    ) u_mac (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (mac_ctl),
        .fa   (fa),
        .fb   (fb),
        .fc   (fc),
        .fd   (fd),
        .done (mac_done),
        .res  (mac_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:     if (s_acc && s_tlast) state_next = S_START;
            S_START:    state_next = ovf_reg ? S_OUT_WAIT : S_ANC_RD;
            S_ANC_RD:   state_next = S_ANC_CMP;
            S_ANC_CMP:  state_next = (i_inc == n_reg) ? S_CLS_INIT : S_ANC_RD;
            S_CLS_INIT: state_next = S_CLS_RD;
            S_CLS_RD:   state_next = S_CLS_P;
            S_CLS_P:
            begin
                priority if (st_rd_x == ax_reg && st_rd_y == ay_reg)
                    state_next = S_CLS_NEXT;
                else if (nc_reg == '0)
                    state_next = S_CLS_NEW;
                else
                    state_next = S_CLS_J;
            end
            S_CLS_J:    state_next = S_CLS_JQ;
            S_CLS_JQ:   state_next = S_CLS_Q;
            S_CLS_Q:    state_next = S_CLS_T;
            S_CLS_T:
            begin
                if (mac_done)
                begin
                    priority if (res_zero)
                        state_next = S_CLS_D1;
                    else if (j_inc == nc_reg)
                        state_next = S_CLS_NEW;
                    else
                        state_next = S_CLS_J;
                end
            end
            S_CLS_D1:   if (mac_done) state_next = S_CLS_D2;
            S_CLS_D2:   if (mac_done) state_next = S_CLS_NEXT;
            S_CLS_NEW:  state_next = S_CLS_NEXT;
            S_CLS_NEXT: state_next = (i_inc == n_reg) ? S_CHK : S_CLS_RD;
            S_CHK:      state_next = (nc_reg < CW'(2)) ? S_OUT_WAIT : S_SRT_RD;
            S_SRT_RD:   state_next = S_SRT_K;
            S_SRT_K:    state_next = S_SRT_KP;
            S_SRT_KP:   state_next = S_SRT_J;
            S_SRT_J:    state_next = (j_reg == '0) ? S_SRT_PUT : S_SRT_JQ;
            S_SRT_JQ:   state_next = S_SRT_Q;
            S_SRT_Q:    state_next = S_SRT_T;
            S_SRT_T:
            begin
                if (mac_done)
                begin
                    state_next = (!res_zero && !res_neg) ? S_SRT_J : S_SRT_PUT;
                end
            end
            S_SRT_PUT:  state_next = (i_inc == nc_reg) ? S_SCN_INIT : S_SRT_RD;
            S_SCN_INIT: state_next = S_SCN_I1;
            S_SCN_I1:   state_next = S_SCN_I2;
            S_SCN_I2:   state_next = (nc_reg == CW'(2)) ? S_OUT_INIT : S_SCN_RD;
            S_SCN_RD:   state_next = S_SCN_P;
            S_SCN_P:    state_next = S_SCN_PP;
            S_SCN_PP:   state_next = S_SCN_TOP;
            S_SCN_TOP:  state_next = (d_reg <= CW'(2)) ? S_SCN_PUSH : S_SCN_O;
            S_SCN_O:    state_next = S_SCN_M;
            S_SCN_M:    state_next = S_SCN_MQ;
            S_SCN_MQ:   state_next = S_SCN_T;
            S_SCN_T:
            begin
                if (mac_done)
                begin
                    state_next = res_neg ? S_SCN_TOP : S_SCN_PUSH;
                end
            end
            S_SCN_PUSH: state_next = (i_inc == nc_reg) ? S_OUT_INIT : S_SCN_RD;
            S_OUT_INIT: state_next = S_OUT_RD;
            S_OUT_RD:   state_next = S_OUT_S;
            S_OUT_S:    state_next = S_OUT_SET;
            S_OUT_SET:  state_next = S_OUT_WAIT;
            S_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    state_next = out_last_reg ? S_LOAD : S_OUT_RD;
                end
            end
            default:    state_next = S_LOAD;
        endcase
    end

    // memory ports and shared unit control
    always_comb
    begin
        s_tready   = (state_reg == S_LOAD);
        m_tvalid   = (state_reg == S_OUT_WAIT);
        st_we      = s_acc && (cnt_reg < MAXC);
        st_raddr   = i_reg[AW-1:0];
        cls_raddr  = j_reg[AW-1:0];
        cls_we     = 1'b0;
        cls_waddr  = j_reg[AW-1:0];
        cls_wdata  = i_reg[AW-1:0];
        hull_raddr = i_reg[AW-1:0];
        hull_we    = 1'b0;
        hull_waddr = d_reg[AW-1:0];
        hull_wdata = key_reg;
        mac_ctl    = '{start: 1'b0, sub: 1'b1};
        fa         = dif(st_rd_x, ax_reg);
        fb         = dif(py_reg, ay_reg);
        fc         = dif(st_rd_y, ay_reg);
        fd         = dif(px_reg, ax_reg);
        unique case (state_reg)
            S_CLS_JQ:   st_raddr = cls_rd;
            S_CLS_Q:    mac_ctl.start = 1'b1;
            S_CLS_T:
            begin
                // same direction: distance of the new point
                mac_ctl = '{start: mac_done && res_zero, sub: 1'b0};
                fa = dif(px_reg, ax_reg);
                fb = dif(px_reg, ax_reg);
                fc = dif(py_reg, ay_reg);
                fd = dif(py_reg, ay_reg);
            end
            S_CLS_D1:
            begin
                mac_ctl = '{start: mac_done, sub: 1'b0};
                fa = dif(qx_reg, ax_reg);
                fb = dif(qx_reg, ax_reg);
                fc = dif(qy_reg, ay_reg);
                fd = dif(qy_reg, ay_reg);
            end
            S_CLS_D2:
            begin
                cls_we = mac_done && (dist_reg > mac_res);
            end
            S_CLS_NEW:
            begin
                cls_we    = 1'b1;
                cls_waddr = nc_reg[AW-1:0];
            end
            S_SRT_RD:   cls_raddr = i_reg[AW-1:0];
            S_SRT_K:    st_raddr = cls_rd;
            S_SRT_J:    cls_raddr = j_dec[AW-1:0];
            S_SRT_JQ:   st_raddr = cls_rd;
            S_SRT_Q:
            begin
                mac_ctl.start = 1'b1;
                fa = dif(px_reg, ax_reg);
                fb = dif(st_rd_y, ay_reg);
                fc = dif(py_reg, ay_reg);
                fd = dif(st_rd_x, ax_reg);
            end
            S_SRT_T:
            begin
                // shift the earlier class up one slot
                cls_we    = mac_done && !res_zero && !res_neg;
                cls_wdata = qslot_reg;
            end
            S_SRT_PUT:
            begin
                cls_we    = 1'b1;
                cls_wdata = key_reg;
            end
            S_SCN_INIT:
            begin
                cls_raddr  = '0;
                hull_we    = 1'b1;
                hull_waddr = '0;
                hull_wdata = aslot_reg;
            end
            S_SCN_I1:
            begin
                cls_raddr  = AW'(1);
                hull_we    = 1'b1;
                hull_waddr = AW'(1);
                hull_wdata = cls_rd;
            end
            S_SCN_I2:
            begin
                hull_we    = 1'b1;
                hull_waddr = AW'(2);
                hull_wdata = cls_rd;
            end
            S_SCN_RD:   cls_raddr = i_reg[AW-1:0];
            S_SCN_P:    st_raddr = cls_rd;
            S_SCN_TOP:  hull_raddr = d_dec2[AW-1:0];
            S_SCN_O:
            begin
                st_raddr   = hull_rd;
                hull_raddr = d_dec[AW-1:0];
            end
            S_SCN_M:    st_raddr = hull_rd;
            S_SCN_MQ:
            begin
                mac_ctl.start = 1'b1;
                fa = dif(st_rd_x, ox_reg);
                fb = dif(py_reg, oy_reg);
                fc = dif(st_rd_y, oy_reg);
                fd = dif(px_reg, ox_reg);
            end
            S_SCN_PUSH: hull_we = 1'b1;
            S_OUT_S:    st_raddr = hull_rd;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_x_mem[cnt_reg[AW-1:0]] <= in_x;
            store_y_mem[cnt_reg[AW-1:0]] <= in_y;
        end
        st_rd_x <= store_x_mem[st_raddr];
        st_rd_y <= store_y_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cls_we)
        begin
            cls_mem[cls_waddr] <= cls_wdata;
        end
        cls_rd <= cls_mem[cls_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hull_we)
        begin
            hull_mem[hull_waddr] <= hull_wdata;
        end
        hull_rd <= hull_mem[hull_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            n_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            nc_reg       <= '0;
            d_reg        <= '0;
            aslot_reg    <= '0;
            out_last_reg <= 1'b0;
            out_st_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (s_acc)
                    begin
                        if (cnt_reg < MAXC)
                            cnt_reg <= cnt_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                    end
                end
                S_START:
                begin
                    n_reg        <= cnt_reg;
                    cnt_reg      <= '0;
                    ovf_reg      <= 1'b0;
                    i_reg        <= '0;
                    d_reg        <= '0;
                    out_last_reg <= 1'b1;
                    out_st_reg   <= ST_OVF;
                end
                S_ANC_CMP:
                begin
                    if (i_reg == '0 || st_rd_y < ay_reg ||
                        (st_rd_y == ay_reg && st_rd_x < ax_reg))
                    begin
                        aslot_reg <= i_reg[AW-1:0];
                    end
                    i_reg <= i_inc;
                end
                S_CLS_INIT:
                begin
                    i_reg  <= '0;
                    nc_reg <= '0;
                end
                S_CLS_P:    j_reg <= '0;
                S_CLS_T:
                begin
                    if (mac_done && !res_zero)
                        j_reg <= j_inc;
                end
                S_CLS_NEW:  nc_reg <= nc_reg + 1'b1;
                S_CLS_NEXT: i_reg <= i_inc;
                S_CHK:
                begin
                    i_reg        <= CW'(1);
                    out_last_reg <= 1'b1;
                    out_st_reg   <= ST_FEW;
                end
                S_SRT_K:    j_reg <= i_reg;
                S_SRT_T:
                begin
                    if (mac_done && !res_zero && !res_neg)
                        j_reg <= j_dec;
                end
                S_SRT_PUT:  i_reg <= i_inc;
                S_SCN_I2:
                begin
                    d_reg <= CW'(3);
                    i_reg <= CW'(2);
                end
                S_SCN_T:
                begin
                    if (mac_done && (res_neg || res_zero))
                        d_reg <= d_dec;
                end
                S_SCN_PUSH:
                begin
                    d_reg <= d_reg + 1'b1;
                    i_reg <= i_inc;
                end
                S_OUT_INIT: i_reg <= '0;
                S_OUT_SET:
                begin
                    out_last_reg <= (i_inc == d_reg);
                    out_st_reg   <= ST_OK;
                end
                S_OUT_WAIT:
                begin
                    if (m_tready)
                        i_reg <= i_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    // coordinate and payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_START:
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
            end
            S_ANC_CMP:
            begin
                if (i_reg == '0 || st_rd_y < ay_reg ||
                    (st_rd_y == ay_reg && st_rd_x < ax_reg))
                begin
                    ax_reg <= st_rd_x;
                    ay_reg <= st_rd_y;
                end
            end
            S_CLS_P:
            begin
                px_reg <= st_rd_x;
                py_reg <= st_rd_y;
            end
            S_CLS_Q:
            begin
                qx_reg <= st_rd_x;
                qy_reg <= st_rd_y;
            end
            S_CLS_D1:   if (mac_done) dist_reg <= mac_res;
            S_SRT_K:    key_reg <= cls_rd;
            S_SRT_KP:
            begin
                px_reg <= st_rd_x;
                py_reg <= st_rd_y;
            end
            S_SRT_JQ:   qslot_reg <= cls_rd;
            S_SCN_P:    key_reg <= cls_rd;
            S_SCN_PP:
            begin
                px_reg <= st_rd_x;
                py_reg <= st_rd_y;
            end
            S_SCN_M:
            begin
                ox_reg <= st_rd_x;
                oy_reg <= st_rd_y;
            end
            S_CHK:
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
            end
            S_OUT_SET:
            begin
                out_x_reg <= st_rd_x;
                out_y_reg <= st_rd_y;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tdata = DW'({out_y_reg, out_x_reg});
    assign m_tlast = out_last_reg;
    assign m_tuser = out_st_reg;

    `ASSERT_NEVER(a_hs_excl, clk, rst_n, s_tready && m_tvalid)
    `ASSERT_LAT(a_mac_lat, clk, rst_n, mac_ctl.start, 4, mac_done)
    `ASSERT_NEVER(a_depth, clk, rst_n, d_reg > MAXC)
    `ASSERT_IMPL(a_err_last, clk, rst_n, m_tvalid && (m_tuser != ST_OK), m_tlast)

endmodule

/* bench/graham_scan_convex_hull_core_tb.sv */
`timescale 1ns / 1ps

module graham_scan_convex_hull_core_tb;
    import gsch_pkg::*;

    localparam int NPTS = 64;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic [1:0]         status;
    } vertex_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    vertex_t hull_expected[$];
    longint  set_x[$];
    longint  set_y[$];
    bit      set_dropped = 1'b0;
    bit      failed = 1'b0;
    int      burst_left = 0;
    int      points_sent = 0;
    int      stall_mode = 0;
    int      stall_count = 0;

    graham_scan_convex_hull_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic longint cross_z(int o, int a, int b);
        longint ax, ay, bx, by;
        ax = set_x[a] - set_x[o];
        ay = set_y[a] - set_y[o];
        bx = set_x[b] - set_x[o];
        by = set_y[b] - set_y[o];
        return ax * by - ay * bx;
    endfunction

    function automatic longint dist_sq(int a, int b);
        longint dx, dy;
        dx = set_x[a] - set_x[b];
        dy = set_y[a] - set_y[b];
        return dx * dx + dy * dy;
    endfunction

    function automatic void push_vertex(longint x, longint y, bit lst, logic [1:0] st);
        vertex_t v;
        v.x = x[15:0];
        v.y = y[15:0];
        v.last = lst;
        v.status = st;
        hull_expected = {hull_expected, v};
    endfunction

    // expected hull of the set just closed
    function automatic void predict_hull();
        int n, anc, nc, d, key, j;
        bit found;
        int cls[NPTS];
        int stk[NPTS];
        n = set_x.size();
        nc = 0;
        if (set_dropped) begin
            push_vertex(0, 0, 1'b1, ST_OVF);
            return;
        end
        anc = 0;
        for (int i = 1; i < n; i++)
            if (set_y[i] < set_y[anc] || (set_y[i] == set_y[anc] && set_x[i] < set_x[anc]))
                anc = i;
        for (int i = 0; i < n; i++) begin
            if (set_x[i] == set_x[anc] && set_y[i] == set_y[anc])
                continue;
            found = 1'b0;
            for (int k = 0; k < nc; k++) begin
                if (cross_z(anc, cls[k], i) == 0) begin
                    if (dist_sq(anc, i) > dist_sq(anc, cls[k]))
                        cls[k] = i;
                    found = 1'b1;
                    break;
                end
            end
            if (!found) begin
                cls[nc] = i;
                nc++;
            end
        end
        if (nc < 2) begin
            push_vertex(0, 0, 1'b1, ST_FEW);
            return;
        end
        for (int i = 1; i < nc; i++) begin
            key = cls[i];
            j = i;
            while (j > 0 && cross_z(anc, key, cls[j-1]) > 0) begin
                cls[j] = cls[j-1];
                j--;
            end
            cls[j] = key;
        end
        stk[0] = anc;
        stk[1] = cls[0];
        stk[2] = cls[1];
        d = 3;
        for (int i = 2; i < nc; i++) begin
            while (d > 2 && cross_z(stk[d-2], stk[d-1], cls[i]) < 0)
                d--;
            if (d > 2 && cross_z(stk[d-2], stk[d-1], cls[i]) == 0)
                d--;
            stk[d] = cls[i];
            d++;
        end
        for (int i = 0; i < d; i++)
            push_vertex(set_x[stk[i]], set_y[stk[i]], i == d - 1, ST_OK);
    endfunction

    task automatic send_point(longint x, longint y, bit lst);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y[15:0], x[15:0]};
        s_tlast <= lst;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        points_sent++;
        if (set_x.size() < NPTS) begin
            set_x = {set_x, x};
            set_y = {set_y, y};
        end else begin
            set_dropped = 1'b1;
        end
        if (lst) begin
            predict_hull();
            set_x.delete();
            set_y.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (hull_expected.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        // single point, then two distinct points (one sent twice): too few directions
        send_point(5, 5, 1);
        send_point(-3, 2, 0);
        send_point(-3, 2, 0);
        send_point(7, 9, 1);
        // all points on one line through the anchor
        send_point(0, 0, 0);
        send_point(2, 2, 0);
        send_point(4, 4, 1);
        // square with interior, edge, and anchor copies
        send_point(-32768, -32768, 0);
        send_point(32767, -32768, 0);
        send_point(0, -32768, 0);
        send_point(32767, 32767, 0);
        send_point(-32768, 32767, 0);
        send_point(0, 0, 0);
        send_point(-32768, -32768, 0);
        send_point(-32768, 0, 1);
        // triangle with farther point on same ray and collinear middle point
        send_point(1, 1, 0);
        send_point(3, 1, 0);
        send_point(2, 1, 0);
        send_point(1, 3, 0);
        send_point(1, 2, 1);
    endtask

    task automatic test_store_overflow();
        for (int i = 0; i < NPTS + 3; i++)
            send_point(longint'($urandom_range(0, 65535)) - 32768,
                       longint'($urandom_range(0, 65535)) - 32768,
                       i == NPTS + 2);
        // exactly full store is still a normal set
        for (int i = 0; i < NPTS; i++)
            send_point(longint'($urandom_range(0, 200)) - 100,
                       longint'($urandom_range(0, 200)) - 100,
                       i == NPTS - 1);
    endtask

    task automatic test_random_sets();
        int n, shape, span;
        longint x, y;
        while (points_sent < 440) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
            shape = $urandom_range(0, 3);
            span = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                case (shape)
                    0: begin
                        x = longint'($urandom_range(0, 65535)) - 32768;
                        y = longint'($urandom_range(0, 65535)) - 32768;
                    end
                    1: begin
                        x = longint'($urandom_range(0, 2 * span)) - span;
                        y = longint'($urandom_range(0, 2 * span)) - span;
                    end
                    2: begin
                        x = $urandom_range(0, 1) ? 32767 : -32768;
                        y = longint'($urandom_range(0, 65535)) - 32768;
                        if ($urandom_range(0, 1)) begin
                            y = x;
                            x = longint'($urandom_range(0, 65535)) - 32768;
                        end
                    end
                    default: begin
                        // points on a few rays for ties in angle
                        x = longint'($urandom_range(0, 4)) * span;
                        y = longint'($urandom_range(0, 4)) * span;
                    end
                endcase
                send_point(x, y, i == n - 1);
            end
            if (points_sent > 300 && points_sent < 320)
                wait_drained();
        end
    endtask

    // receiver stall pattern
    always @(posedge clk) begin
        if (stall_count == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_count <= $urandom_range(10, 200);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 15) != 0);
        endcase
    end

    // result checker
    always @(posedge clk) begin
        vertex_t e;
        if (rst_n && m_tvalid && m_tready) begin
            if (hull_expected.size() == 0) begin
                $display("%0t unexpected result x=%0d y=%0d last=%0b status=%0d", $time,
                         $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast, m_tuser);
                failed = 1'b1;
            end else begin
                e = hull_expected.pop_front();
                if (m_tdata[15:0] !== e.x || m_tdata[31:16] !== e.y || m_tlast !== e.last
                    || m_tuser !== e.status) begin
                    $display({"%0t mismatch: expected x=%0d y=%0d last=%0b status=%0d,",
                              " actual x=%0d y=%0d last=%0b status=%0d"},
                             $time, e.x, e.y, e.last, e.status,
                             $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_store_overflow();
        test_random_sets();
        wait_drained();
        repeat (200) @(posedge clk);
        if (hull_expected.size() == 0 && !failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

endmodule

/* graham_scan_convex_hull_core.f */
+incdir+design
design/gsch_pkg.sv
design/gsch_mac.sv
design/graham_scan_convex_hull_core.sv
bench/graham_scan_convex_hull_core_tb.sv
